// ----- rtl/sha256_stream_hasher_defines.svh -----
// Assertion macros shared by the hasher RTL.
// Both expect signals named clk and rst_n in the calling scope.
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define SHS_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define SHS_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/shs_pkg.sv -----
package shs_pkg;

    typedef struct packed {
        logic [31:0] message_word;
        logic [2:0]  valid_bytes;
        logic        message_end;
    } shs_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        digest_last;
    } shs_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_FOLD,
        S_PAD,
        S_OUT
    } shs_state_t;

    // Commands from the sequencer to the round unit; step also advances the message schedule.
    typedef struct packed {
        logic load;
        logic step;
        logic fold;
        logic init;
    } shs_ctrl_t;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] PAD_WORD = 32'h80000000;

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

// ----- rtl/shs_sched.sv -----
module shs_sched (
    input  logic        clk,
    input  logic        push,
    input  logic [31:0] push_word,
    input  logic        step,
    output logic [31:0] w_word
);
    import shs_pkg::*;

    // Sixteen-word window; entry 0 is the word used by the current round.
    logic [31:0] win_reg  [16];
    logic [31:0] win_next [16];
    logic [31:0] expand_word;

    assign expand_word = small_sigma1(win_reg[14]) + win_reg[9]
                       + small_sigma0(win_reg[1]) + win_reg[0];
    assign w_word = win_reg[0];

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            win_next[i] = win_reg[i];
        end
        if (push || step)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[15] = push ? push_word : expand_word;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 16; i++)
        begin
            win_reg[i] <= win_next[i];
        end
    end

endmodule

// ----- rtl/shs_round.sv -----
module shs_round (
    input  logic              clk,
    input  logic              rst_n,
    input  shs_pkg::shs_ctrl_t ctrl,
    input  logic [31:0]       k_word,
    input  logic [31:0]       w_word,
    input  logic [2:0]        out_idx,
    output logic [31:0]       chain_word
);
    import shs_pkg::*;

    logic [31:0] v_reg      [8];
    logic [31:0] v_next     [8];
    logic [31:0] chain_reg  [8];
    logic [31:0] chain_next [8];
    logic [31:0] choose;
    logic [31:0] major;
    logic [31:0] tmp1;
    logic [31:0] tmp2;

    assign choose = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign major  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign tmp1   = v_reg[7] + big_sigma1(v_reg[4]) + choose + k_word + w_word;
    assign tmp2   = big_sigma0(v_reg[0]) + major;
    assign chain_word = chain_reg[out_idx];

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            v_next[i]     = v_reg[i];
            chain_next[i] = chain_reg[i];
        end
        if (ctrl.load)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_next[i] = chain_reg[i];
            end
        end
        else if (ctrl.step)
        begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + tmp1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = tmp1 + tmp2;
        end
        if (ctrl.fold)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_next[i] = chain_reg[i] + v_reg[i];
            end
        end
        else if (ctrl.init)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_next[i] = INIT_HASH[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 8; i++)
        begin
            v_reg[i] <= v_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= INIT_HASH[i];
            end
        end
        else
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= chain_next[i];
            end
        end
    end

endmodule

// ----- rtl/sha256_stream_hasher.sv -----
// SHA-256 hasher that takes a message as a stream of 32-bit words, first byte in bits 31..24,
// and returns the eight digest words H0..H7 as eight transfers on the digest channel, with
// digest_last marking H7. valid_bytes is read only on the word flagged message_end (values
// above four count as four; zero means the message ended on the previous word). A word that
// does not complete a 16-word block is taken without a stall. The word that completes a block
// holds the input stalled after its transfer, because a single round unit performs one of the
// 64 compression rounds per cycle and then adds the result into the chaining value. At message
// end the sequencer pushes the padding and the 64-bit length one word per cycle, except while
// a full block is compressed; it runs one or two compressions, and then offers the digest;
// the input stays stalled until the H7 transfer, after which the block is ready for a new
// message.
`include "sha256_stream_hasher_defines.svh"

module sha256_stream_hasher (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              msg_valid,
    output logic              msg_stall,
    input  shs_pkg::shs_in_t  msg_data,
    output logic              digest_valid,
    input  logic              digest_stall,
    output shs_pkg::shs_out_t digest_data
);
    import shs_pkg::*;

    shs_state_t  state_reg;
    shs_state_t  state_next;
    logic [3:0]  word_pos_reg;
    logic [3:0]  word_pos_next;
    logic [5:0]  round_reg;
    logic [5:0]  round_next;
    logic [63:0] bit_len_reg;
    logic [63:0] bit_len_next;
    logic        pad_active_reg;
    logic        pad_active_next;
    logic        pad_first_reg;
    logic        pad_first_next;
    logic        len_hi_done_reg;
    logic        len_hi_done_next;
    logic        len_lo_done_reg;
    logic        len_lo_done_next;
    logic [2:0]  out_idx_reg;
    logic [2:0]  out_idx_next;

    logic        msg_take;
    logic        digest_take;
    logic [2:0]  byte_count;
    logic [31:0] end_word;
    logic        push;
    logic [31:0] push_word;
    logic [31:0] w_word;
    logic [31:0] chain_word;
    shs_ctrl_t   ctrl;

    assign msg_take    = msg_valid && !msg_stall;
    assign digest_take = digest_valid && !digest_stall;
    assign byte_count  = (msg_data.valid_bytes > 3'd4) ? 3'd4 : msg_data.valid_bytes;

    // The word that ends the message keeps its valid bytes and carries the padding byte
    // right after them; a full end word is stored unchanged and the padding follows.
    always_comb
    begin
        case (byte_count)
            3'd0:    end_word = PAD_WORD;
            3'd1:    end_word = {msg_data.message_word[31:24], 24'h800000};
            3'd2:    end_word = {msg_data.message_word[31:16], 16'h8000};
            3'd3:    end_word = {msg_data.message_word[31:8], 8'h80};
            default: end_word = msg_data.message_word;
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        word_pos_next    = word_pos_reg;
        round_next       = round_reg;
        bit_len_next     = bit_len_reg;
        pad_active_next  = pad_active_reg;
        pad_first_next   = pad_first_reg;
        len_hi_done_next = len_hi_done_reg;
        len_lo_done_next = len_lo_done_reg;
        out_idx_next     = out_idx_reg;
        push             = 1'b0;
        push_word        = msg_data.message_word;
        ctrl             = '0;
        msg_stall        = 1'b1;
        digest_valid     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                msg_stall = 1'b0;
                if (msg_valid)
                begin
                    push = 1'b1;
                    if (msg_data.message_end)
                    begin
                        push_word       = end_word;
                        bit_len_next    = bit_len_reg + {58'd0, byte_count, 3'b000};
                        pad_active_next = 1'b1;
                        pad_first_next  = (byte_count == 3'd4);
                        state_next      = S_PAD;
                    end
                    else
                    begin
                        bit_len_next = bit_len_reg + 64'd32;
                    end
                end
            end
            S_PAD:
            begin
                // One padding word per cycle: the pending 0x80 byte, zero fill, and the
                // length in the last two positions of the final block.
                push = 1'b1;
                if (pad_first_reg)
                begin
                    push_word      = PAD_WORD;
                    pad_first_next = 1'b0;
                end
                else if (word_pos_reg == 4'd14)
                begin
                    push_word        = bit_len_reg[63:32];
                    len_hi_done_next = 1'b1;
                end
                else if (word_pos_reg == 4'd15 && len_hi_done_reg)
                begin
                    push_word        = bit_len_reg[31:0];
                    len_lo_done_next = 1'b1;
                end
                else
                begin
                    push_word = 32'd0;
                end
            end
            S_ROUND:
            begin
                ctrl.step  = 1'b1;
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                ctrl.fold = 1'b1;
                if (len_lo_done_reg)
                begin
                    state_next = S_OUT;
                end
                else if (pad_active_reg)
                begin
                    state_next = S_PAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                digest_valid = 1'b1;
                if (!digest_stall)
                begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == 3'd7)
                    begin
                        ctrl.init        = 1'b1;
                        bit_len_next     = 64'd0;
                        pad_active_next  = 1'b0;
                        len_hi_done_next = 1'b0;
                        len_lo_done_next = 1'b0;
                        state_next       = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Every pushed word advances the block position; the sixteenth starts a compression.
        if (push)
        begin
            word_pos_next = word_pos_reg + 4'd1;
            if (word_pos_reg == 4'd15)
            begin
                ctrl.load  = 1'b1;
                round_next = 6'd0;
                state_next = S_ROUND;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            word_pos_reg    <= 4'd0;
            round_reg       <= 6'd0;
            bit_len_reg     <= 64'd0;
            pad_active_reg  <= 1'b0;
            pad_first_reg   <= 1'b0;
            len_hi_done_reg <= 1'b0;
            len_lo_done_reg <= 1'b0;
            out_idx_reg     <= 3'd0;
        end
        else
        begin
            state_reg       <= state_next;
            word_pos_reg    <= word_pos_next;
            round_reg       <= round_next;
            bit_len_reg     <= bit_len_next;
            pad_active_reg  <= pad_active_next;
            pad_first_reg   <= pad_first_next;
            len_hi_done_reg <= len_hi_done_next;
            len_lo_done_reg <= len_lo_done_next;
            out_idx_reg     <= out_idx_next;
        end
    end

    shs_sched u_sched (
        .clk       (clk),
        .push      (push),
        .push_word (push_word),
        .step      (ctrl.step),
        .w_word    (w_word)
    );

    shs_round u_round (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .k_word     (ROUND_K[round_reg]),
        .w_word     (w_word),
        .out_idx    (out_idx_reg),
        .chain_word (chain_word)
    );

    assign digest_data.digest_word = chain_word;
    assign digest_data.digest_last = (out_idx_reg == 3'd7);

    // No message word is taken while a digest is still being delivered.
    `SHS_ASSERT_SAME(a_no_take_during_digest, msg_take, !digest_valid,
        "message word taken during digest output")

    // The last round is always followed by the chaining update.
    `SHS_ASSERT_NEXT(a_fold_after_rounds, state_reg == S_ROUND && round_reg == 6'd63,
        state_reg == S_FOLD, "last round not followed by fold")

    // The digest is offered only on a block boundary.
    `SHS_ASSERT_SAME(a_digest_on_boundary, digest_valid, word_pos_reg == 4'd0,
        "digest offered inside a block")

    // After the H7 transfer the message state is back at its start.
    `SHS_ASSERT_NEXT(a_clear_after_digest, digest_take && digest_data.digest_last,
        bit_len_reg == 64'd0 && !pad_active_reg && state_reg == S_IDLE,
        "message state not cleared after digest")

endmodule
